// ----- design/rv32_pkg.sv -----
// Package for the RV32IM execute block: opcodes, function codes, controller types.
// No dependencies.
`default_nettype none
package rv32_pkg;

  localparam int XLEN = 32;
  localparam int RegIdxW = 5;
  localparam int DivCountW = 6;

  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_PCUPPER = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;

  localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;    // latch request
    logic read_regs;  // register operand read
    logic exec;       // decode and compute
    logic mul_step;   // register product
    logic div_start;
    logic div_step;
    logic finish;     // write back and load output
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_mul;
    logic is_div;
    logic div_last;
  } dp_status_t;

endpackage
`default_nettype wire

// ----- design/rv32_datapath.sv -----
// Datapath: register file, decoder, ALU, multiplier and a radix-2 divider.
// Depends on rv32_pkg.
`default_nettype none
module rv32_datapath (
  input  wire                  clk,
  input  wire                  rst,
  input  wire rv32_pkg::dp_cmd_t cmd,
  output rv32_pkg::dp_status_t sts,
  input  wire [31:0]           in_instr,
  input  wire [31:0]           in_pc,
  output logic [31:0]          res_next_pc,
  output logic                 res_reg_write,
  output logic [4:0]           res_dest_index,
  output logic [31:0]          res_dest_value,
  output logic                 res_illegal
);
  import rv32_pkg::*;

  logic [31:0] regs [32];
  logic [31:0] ir, pcr, va, vb;

  // decoded result, before mul/div
  logic [31:0] val, nxt;
  logic        wr, bad;
  logic [31:0] val_r, nxt_r;
  logic        wr_r, bad_r;

  logic [6:0] major, fn7;
  logic [2:0] fn3;
  logic [4:0] dreg;
  logic [31:0] i_val, u_val, j_val, b_val, seq;
  logic mulop, divop;

  assign major = ir[6:0];
  assign fn3   = ir[14:12];
  assign fn7   = ir[31:25];
  assign dreg  = ir[11:7];
  assign i_val = {{20{ir[31]}}, ir[31:20]};
  assign u_val = {ir[31:12], 12'b0};
  assign j_val = {{12{ir[31]}}, ir[19:12], ir[20], ir[30:21], 1'b0};
  assign b_val = {{20{ir[31]}}, ir[7], ir[30:25], ir[11:8], 1'b0};
  assign seq   = pcr + 32'd4;
  assign mulop = (major == OP_REG) && (fn7 == F7_MULDIV) && !fn3[2];
  assign divop = (major == OP_REG) && (fn7 == F7_MULDIV) && fn3[2];

  function automatic logic lt_s(input logic [31:0] a, input logic [31:0] b);
    return (a ^ SIGN_BIT) < (b ^ SIGN_BIT);
  endfunction

  always_comb begin
    logic take;
    logic [31:0] opb;
    take = 1'b0;
    val  = '0;
    nxt  = seq;
    wr   = 1'b0;
    bad  = 1'b0;
    opb  = (major == OP_IMM) ? i_val : vb;
    unique case (major)
      OP_LUI: begin val = u_val; wr = 1'b1; end
      OP_PCUPPER: begin val = pcr + u_val; wr = 1'b1; end
      OP_JAL: begin val = seq; wr = 1'b1; nxt = pcr + j_val; end
      OP_JALR: begin
        if (fn3 != 3'd0) bad = 1'b1;
        else begin
          nxt = (va + i_val) & ~32'd1;
          val = seq;
          wr = 1'b1;
        end
      end
      OP_BRANCH: begin
        unique case (fn3)
          3'd0: take = (va == vb);
          3'd1: take = (va != vb);
          3'd4: take = lt_s(va, vb);
          3'd5: take = !lt_s(va, vb);
          3'd6: take = (va < vb);
          3'd7: take = (va >= vb);
          default: bad = 1'b1;
        endcase
        if (take) nxt = pcr + b_val;
      end
      OP_IMM, OP_REG: begin
        wr = 1'b1;
        if (major == OP_REG && fn7 == F7_MULDIV) begin
          val = '0;
        end else if (major == OP_REG && !(fn7 == F7_BASE || fn7 == F7_ALT)) begin
          bad = 1'b1;
        end else if (major == OP_REG && fn7 == F7_ALT && fn3 != 3'd0 && fn3 != 3'd5) begin
          bad = 1'b1;
        end else begin
          unique case (fn3)
            3'd0: val = (major == OP_REG && fn7 == F7_ALT) ? va - vb : va + opb;
            3'd1: begin
              if (major == OP_IMM && fn7 != F7_BASE) bad = 1'b1;
              else val = va << opb[4:0];
            end
            3'd2: val = {31'd0, lt_s(va, opb)};
            3'd3: val = {31'd0, va < opb};
            3'd4: val = va ^ opb;
            3'd5: begin
              if (fn7 == F7_BASE) val = va >> opb[4:0];
              else if (fn7 == F7_ALT) val = 32'($signed(va) >>> opb[4:0]);
              else bad = 1'b1;
            end
            3'd6: val = va | opb;
            default: val = va & opb;
          endcase
        end
      end
      default: bad = 1'b1;
    endcase
  end

  // multiplier: one 33x33 signed product, registered
  logic [32:0] ma, mb;
  logic [63:0] prod;
  assign ma = {(fn3 != 3'd3) & va[31], va};
  assign mb = {(fn3 == 3'd1) & vb[31], vb};

  // divider: magnitudes, one quotient bit per cycle
  logic [31:0] dq, dd;
  logic [31:0] drem;
  logic [DivCountW-1:0] dcnt;
  logic dsgn_q, dsgn_r, dzero, dovf;
  logic [32:0] dtrial;
  assign dtrial = {drem, dq[31]} - {1'b0, dd};
  assign sts.is_mul = mulop;
  assign sts.is_div = divop;
  assign sts.div_last = (dcnt == DivCountW'(31));

  logic [31:0] mdv;
  always_comb begin
    logic [31:0] q, r;
    q = dsgn_q ? 32'd0 - dq : dq;
    r = dsgn_r ? 32'd0 - drem : drem;
    if (mulop) mdv = (fn3 == 3'd0) ? prod[31:0] : prod[63:32];
    else if (dzero) mdv = fn3[1] ? va : ALL_ONES;
    else if (dovf) mdv = fn3[1] ? 32'd0 : SIGN_BIT;
    else mdv = fn3[1] ? r : q;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ir  <= in_instr;
      pcr <= in_pc;
    end
    if (cmd.read_regs) begin
      va <= (ir[19:15] == 5'd0) ? 32'd0 : regs[ir[19:15]];
      vb <= (ir[24:20] == 5'd0) ? 32'd0 : regs[ir[24:20]];
    end
    if (cmd.exec) begin
      val_r <= val;
      nxt_r <= nxt;
      wr_r  <= wr & ~bad & (dreg != 5'd0);
      bad_r <= bad;
    end
    if (cmd.mul_step) prod <= 64'($signed(ma) * $signed(mb));
    if (cmd.div_start) begin
      dsgn_q <= fn3[0] ? 1'b0 : (va[31] ^ vb[31]);
      dsgn_r <= fn3[0] ? 1'b0 : va[31];
      dq     <= (!fn3[0] && va[31]) ? 32'd0 - va : va;
      dd     <= (!fn3[0] && vb[31]) ? 32'd0 - vb : vb;
      drem   <= '0;
      dcnt   <= '0;
      dzero  <= (vb == 32'd0);
      dovf   <= !fn3[0] && (va == SIGN_BIT) && (vb == ALL_ONES);
    end else if (cmd.div_step) begin
      if (!dtrial[32]) begin
        drem <= dtrial[31:0];
        dq   <= {dq[30:0], 1'b1};
      end else begin
        drem <= {drem[30:0], dq[31]};
        dq   <= {dq[30:0], 1'b0};
      end
      dcnt <= dcnt + DivCountW'(1);
    end
    if (cmd.finish) begin
      res_next_pc    <= nxt_r;
      res_reg_write  <= wr_r;
      res_dest_index <= wr_r ? dreg : 5'd0;
      res_dest_value <= wr_r ? ((mulop || divop) ? mdv : val_r) : 32'd0;
      res_illegal    <= bad_r;
      if (wr_r) regs[dreg] <= (mulop || divop) ? mdv : val_r;
    end
    if (rst) begin
      // clear the register file
      for (int k = 0; k < 32; k++) regs[5'(k)] <= '0;
    end
  end
endmodule
`default_nettype wire

// ----- design/rv32_control.sv -----
// Controller: sequences capture, read, execute, multiply/divide and write back.
// Depends on rv32_pkg.
`default_nettype none
module rv32_control (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    s_tvalid,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  wire                    m_tready,
  output rv32_pkg::dp_cmd_t      cmd,
  input  wire rv32_pkg::dp_status_t sts
);
  import rv32_pkg::*;

  state_t state, state_next;
  logic   out_valid, out_valid_next;

  assign m_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !m_tready;
    cmd            = '0;
    s_tready       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read_regs = 1'b1;
        state_next    = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.is_mul) begin
          cmd.mul_step = 1'b1;
          state_next = ST_DONE;
        end else if (sts.is_div) begin
          cmd.div_start = 1'b1;
          state_next = ST_DIV;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        // hold the result until the output register is free
        if (!out_valid || m_tready) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- design/rv32im_integer_execute.sv -----
// RV32IM integer execute block: stream ports around controller and datapath.
// Depends on rv32_pkg, rv32_control, rv32_datapath.
//
// Usage: one request on the slave channel carries an instruction word and its
// pc; one result on the master channel carries the next pc and register write.
// Steps: after a request is accepted, ALU, jump, branch and multiply
// instructions pass register read, execute and write back; divide and
// remainder add 32 radix-2 divider steps of one quotient bit each between
// execute and write back. One request is in flight at a time; the next is
// taken the cycle after the current result is loaded into the output register.
// When the receiver stalls, the result holds in the output register and the
// following request is still taken and executed; it waits in write back, and
// no further request is taken until the output register frees.
// Reset: rst clears the register file and the output valid; a request can be
// accepted once rst drops.
`default_nettype none
module rv32im_integer_execute (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire  [63:0]  s_tdata,   // instr_word[31:0], pc[63:32]
  output logic         m_tvalid,
  input  wire          m_tready,
  output logic [71:0]  m_tdata    // next_pc, reg_write, dest_index, dest_value, illegal, pad
);
  import rv32_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t sts;
  logic [31:0] next_pc, dest_value;
  logic        reg_write, illegal;
  logic [4:0]  dest_index;

  rv32_control u_ctl (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cmd(cmd), .sts(sts)
  );

  rv32_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_instr(s_tdata[31:0]), .in_pc(s_tdata[63:32]),
    .res_next_pc(next_pc), .res_reg_write(reg_write), .res_dest_index(dest_index),
    .res_dest_value(dest_value), .res_illegal(illegal)
  );

  assign m_tdata = {1'b0, illegal, dest_value, dest_index, reg_write, next_pc};
endmodule
`default_nettype wire
